// ----- rtl/tts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task tick scheduler package
// Shared constants for the task tick scheduler: policy and command codes,
// default sizes and the packing of the stream payloads.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Scheduling policies held in the configuration register.
  localparam int POLICY_W = 2;
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SRTF = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd2;

  // Input commands carried on in_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Default sizes.
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the stream payloads.
  localparam int FIELD_W   = 16;
  localparam int TASK_ID_W = 4;

  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_BITS   = 6 * FIELD_W - FIELD_W + TASK_ID_W + 3;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/tts_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/task_tick_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task tick scheduler
// Loads tasks into a table and, on each tick beat, runs one unit of work of
// the task chosen by the fifo, shortest-remaining-time or round-robin policy.
// ----------------------------------------------------------------------------
// Flow: a load beat is written in the cycle it is accepted and the next
// beat may follow at once. A tick beat passes the scan, update, wait and
// output states before the next beat is taken: one compare unit walks the
// table an entry a cycle through the registered RAM read port, a shared
// subtractor serves the update and wait states, and the output state raises
// out_tvalid once any earlier result is taken. Reset (rst_n low, synchronous)
// empties the table, clears the time and rotation point and selects the fifo policy.
module task_tick_scheduler_core #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = tts_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: policy register.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tts_pkg::POLICY_W-1:0]    cfg_data,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] arrive_at, [31:16] work_len
  input  logic [tts_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] command
  input  logic                            in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] tick_time, [16] running_valid, [20:17] running_task,
  // [36:21] remaining_before, [37] finished, [53:38] finish_at,
  // [69:54] turnaround, [85:70] queue_delay, [86] all_done, [87] zero
  output logic [tts_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import tts_pkg::*;

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int ENT_W  = 3 * TIME_BITS;
  localparam int WIDE_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [WIDE_W-1:0]    TIME_MAX_W = WIDE_W'(TIME_MAX);
  localparam logic [WIDE_W-1:0]    FIELD_MAX_W = WIDE_W'({FIELD_W{1'b1}});

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_WAITC  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [POLICY_W-1:0]   policy_r, policy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      act_r, act_nxt;
  logic [TIME_BITS-1:0]  time_r, time_nxt;
  logic [IDX_W-1:0]      rot_r, rot_nxt;
  logic [CNT_W-1:0]      issue_r, issue_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  found_r, found_nxt;
  logic                  stop_r, stop_nxt;
  logic                  fin_r, fin_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]  best_arr_r, best_arr_nxt;
  logic [TIME_BITS-1:0]  best_srv_r, best_srv_nxt;
  logic [TIME_BITS-1:0]  best_rem_r, best_rem_nxt;
  logic [TIME_BITS-1:0]  comp_r, comp_nxt;
  logic [TIME_BITS-1:0]  resp_r, resp_nxt;
  logic [TIME_BITS-1:0]  wait_r, wait_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // RAM signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  // Entry read back from the table.
  logic [TIME_BITS-1:0] d_arr, d_srv, d_rem;
  logic                 d_arrived, d_ready, take;

  // Saturated load values.
  logic [WIDE_W-1:0]    ld_arr_w, ld_srv_w;
  logic [TIME_BITS-1:0] ld_arr, ld_srv;

  // Shared subtractor.
  logic [TIME_BITS-1:0] sub_a, sub_b, sub_res;
  logic [TIME_BITS:0]   sub_full;

  logic [TIME_BITS-1:0] comp_val, rem_dec;
  logic                 in_beat, out_beat;
  logic [CNT_W-1:0]     addr_inc, best_inc;
  logic [IDX_W-1:0]     scan_start;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [TIME_BITS-1:0] v);
    logic [WIDE_W-1:0] v_w;
    v_w = WIDE_W'(v);
    return (v_w > FIELD_MAX_W) ? {FIELD_W{1'b1}} : v_w[FIELD_W-1:0];
  endfunction

  tts_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ld_arr_w = WIDE_W'(in_tdata[FIELD_W-1:0]);
  assign ld_srv_w = WIDE_W'(in_tdata[2*FIELD_W-1:FIELD_W]);
  assign ld_arr   = (ld_arr_w > TIME_MAX_W) ? TIME_MAX : ld_arr_w[TIME_BITS-1:0];
  assign ld_srv   = (ld_srv_w > TIME_MAX_W) ? TIME_MAX : ld_srv_w[TIME_BITS-1:0];

  assign d_rem = ram_rdata[TIME_BITS-1:0];
  assign d_srv = ram_rdata[2*TIME_BITS-1:TIME_BITS];
  assign d_arr = ram_rdata[3*TIME_BITS-1:2*TIME_BITS];
  assign d_arrived = (d_arr <= time_r);
  assign d_ready   = d_arrived && (d_rem != '0);

  always_comb begin
    take = 1'b0;
    unique case (policy_r)
      POL_SRTF: take = d_ready && (!found_r || (d_rem < best_rem_r));
      POL_RR:   take = d_ready && !found_r;
      default:  take = !stop_r && (d_rem != '0) && d_arrived;
    endcase
  end

  assign comp_val = (time_r == TIME_MAX) ? time_r : time_r + 1'b1;
  assign rem_dec  = best_rem_r - 1'b1;
  assign addr_inc = CNT_W'(addr_r) + CNT_W'(1);
  assign best_inc = CNT_W'(best_idx_r) + CNT_W'(1);
  // Only round robin starts the walk at the rotation point.
  assign scan_start = ((policy_r == POL_RR) && (CNT_W'(rot_r) < cnt_r)) ? rot_r : '0;

  // One subtractor serves both the response and the wait time; a negative
  // difference floors at zero.
  assign sub_a    = (state_r == ST_UPDATE) ? comp_val : resp_r;
  assign sub_b    = (state_r == ST_UPDATE) ? best_arr_r : best_srv_r;
  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_res  = sub_full[TIME_BITS] ? '0 : sub_full[TIME_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    time_nxt      = time_r;
    rot_nxt       = rot_r;
    issue_nxt     = issue_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    stop_nxt      = stop_r;
    fin_nxt       = fin_r;
    best_idx_nxt  = best_idx_r;
    best_arr_nxt  = best_arr_r;
    best_srv_nxt  = best_srv_r;
    best_rem_nxt  = best_rem_r;
    comp_nxt      = comp_r;
    resp_nxt      = resp_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_beat ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = best_idx_r;
    ram_wdata     = {best_arr_r, best_srv_r, rem_dec};

    if (cfg_valid && cfg_ready) begin
      policy_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && (in_tuser == CMD_LOAD)) begin
          // A load into a full table is dropped.
          if (cnt_r < CNT_W'(MAX_TASKS)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[IDX_W-1:0];
            ram_wdata = {ld_arr, ld_srv, ld_srv};
            cnt_nxt   = cnt_r + 1'b1;
            if (ld_srv != '0) begin
              act_nxt = act_r + 1'b1;
            end
          end
        end else if (in_beat) begin
          state_nxt = ST_SCAN;
          issue_nxt = '0;
          addr_nxt  = scan_start;
          found_nxt = 1'b0;
          stop_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue_r < cnt_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = addr_r;
          issue_nxt  = issue_r + 1'b1;
          addr_nxt   = (addr_inc == cnt_r) ? '0 : addr_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_UPDATE;
        end
        if (rd_vld_r) begin
          // In fifo order only the first unfinished entry counts.
          if ((policy_r != POL_SRTF) && (policy_r != POL_RR) && (d_rem != '0)) begin
            stop_nxt = 1'b1;
          end
          if (take) begin
            found_nxt    = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_arr_nxt = d_arr;
            best_srv_nxt = d_srv;
            best_rem_nxt = d_rem;
          end
        end
      end
      ST_UPDATE: begin
        comp_nxt = comp_val;
        resp_nxt = sub_res;
        fin_nxt  = found_r && (rem_dec == '0);
        if (found_r) begin
          ram_we = 1'b1;
          if (rem_dec == '0) begin
            act_nxt = act_r - 1'b1;
          end
          if (policy_r == POL_RR) begin
            rot_nxt = (best_inc < cnt_r) ? best_idx_r + 1'b1 : '0;
          end
        end else if (policy_r == POL_RR) begin
          rot_nxt = '0;
        end
        state_nxt = ST_WAITC;
      end
      ST_WAITC: begin
        wait_nxt  = sub_res;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[15:0] = sat_field(time_r);
          out_data_nxt[86]   = (act_r == '0);
          if (found_r) begin
            out_data_nxt[16]    = 1'b1;
            out_data_nxt[20:17] = TASK_ID_W'(best_idx_r);
            out_data_nxt[36:21] = sat_field(best_rem_r);
            if (fin_r) begin
              out_data_nxt[37]    = 1'b1;
              out_data_nxt[53:38] = sat_field(comp_r);
              out_data_nxt[69:54] = sat_field(resp_r);
              out_data_nxt[85:70] = sat_field(wait_r);
            end
          end
          time_nxt  = comp_val;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POL_FIFO;
      cnt_r       <= '0;
      act_r       <= '0;
      time_r      <= '0;
      rot_r       <= '0;
      issue_r     <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      stop_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      time_r      <= time_nxt;
      rot_r       <= rot_nxt;
      issue_r     <= issue_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      stop_r      <= stop_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_arr_r <= best_arr_nxt;
    best_srv_r <= best_srv_nxt;
    best_rem_r <= best_rem_nxt;
    comp_r     <= comp_nxt;
    resp_r     <= resp_nxt;
    wait_r     <= wait_nxt;
    out_data_r <= out_data_nxt;
  end

  // The count of unfinished tasks can never exceed the table fill.
  a_act_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    act_r <= cnt_r)
    else $error("unfinished task count exceeds table fill");

  a_cnt_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TASKS))
    else $error("table fill exceeds its depth");

  // The scheduler clock never runs backwards.
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> time_r >= $past(time_r))
    else $error("current time decreased");

  // A finished task must also be reported as having run.
  a_fin_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[37]) |-> out_data_r[16])
    else $error("finished reported without a running task");

endmodule

// ----- test/tb_task_tick_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task tick scheduler testbench
// Drives load and tick beats into the scheduler core under every policy and
// checks each result beat against a cycle-free model of the task table. A
// short directed table comes first, then well-formed random task loads mixed
// with tick beats, random stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_task_tick_scheduler_core;
  import tts_pkg::*;

  localparam int N_SLOTS      = MAX_TASKS_DEF;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int SETTLE       = MAX_TASKS_DEF + 24;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 600;
  localparam int DIR_ROWS     = 24;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        running_valid;
    logic [3:0]  running_task;
    logic [15:0] remaining_before;
    logic        finished;
    logic [15:0] finish_at;
    logic [15:0] turnaround;
    logic [15:0] queue_delay;
    logic        all_done;
  } tick_report_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [15:0]  val_a;   // arrival time, or the policy for a register row
    logic [15:0]  val_b;   // service time
    logic         typed;
    tick_report_t want;
  } dir_row_t;

  localparam tick_report_t NO_WANT = '0;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [POLICY_W-1:0]    cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;

  // Model of the task table.
  logic [15:0]         sched_arrival [N_SLOTS];
  logic [15:0]         sched_service [N_SLOTS];
  logic [15:0]         sched_left    [N_SLOTS];
  int                  sched_count;
  logic [15:0]         sched_time;
  int                  sched_rot;
  logic [POLICY_W-1:0] sched_policy;

  tick_report_t pending_ticks [$];
  tick_report_t mon_got;
  tick_report_t mon_want;

  int  fails;
  int  results_seen;
  int  loads_taken;
  int  loads_refused;
  int  ticks_run;
  int  ticks_idle;
  int  completions;
  bit  steady;
  bit  held;

  // Directed table: the typed rows are the ones whose outcome is obvious.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TICK, 16'd0, 16'd0, 1'b1,
      '{16'd0, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{ROW_LOAD, 16'd0, 16'd1, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b1,
      '{16'd1, 1'b1, 4'd0, 16'd1, 1'b1, 16'd2, 16'd2, 16'd1, 1'b1}},
    '{ROW_LOAD, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b1,
      '{16'd2, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{ROW_CFG,  16'(POL_UNUSED), 16'd0, 1'b0, NO_WANT},
    '{ROW_LOAD, 16'd5, 16'd2, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_CFG,  16'(POL_SRTF), 16'd0, 1'b0, NO_WANT},
    '{ROW_LOAD, 16'd0, 16'd3, 1'b0, NO_WANT},
    '{ROW_LOAD, 16'd0, 16'd1, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_CFG,  16'(POL_RR), 16'd0, 1'b0, NO_WANT},
    '{ROW_LOAD, 16'd0, 16'd2, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b0, NO_WANT},
    '{ROW_TICK, 16'd0, 16'd0, 1'b1,
      '{16'd13, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{ROW_CFG,  16'(POL_FIFO), 16'd0, 1'b0, NO_WANT}
  };

  logic [POLICY_W-1:0] phase_pol [PHASES] = '{
    POL_RR, POL_SRTF, POL_FIFO, POL_UNUSED, POL_SRTF, POL_RR, POL_FIFO, POL_RR
  };

  task_tick_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit slot_ready(input int idx);
    return sched_arrival[idx] <= sched_time && sched_left[idx] != 16'd0;
  endfunction

  function automatic bit sched_all_done();
    bit done;
    done = 1'b1;
    for (int j = 0; j < sched_count; j++) begin
      if (sched_left[j] != 16'd0) done = 1'b0;
    end
    return done;
  endfunction

  function automatic void table_append(input logic [15:0] arr, input logic [15:0] svc);
    if (sched_count < N_SLOTS) begin
      sched_arrival[sched_count] = arr;
      sched_service[sched_count] = svc;
      sched_left[sched_count]    = svc;
      sched_count++;
      loads_taken++;
    end else begin
      loads_refused++;
    end
  endfunction

  // Runs one unit of work on the model and returns the report of that tick.
  function automatic tick_report_t schedule_tick();
    tick_report_t r;
    int           sel;
    int           start;
    int           k;
    bit           hit;
    logic [15:0]  comp;
    logic [15:0]  resp;
    r   = '0;
    sel = -1;
    hit = 1'b0;
    r.tick_time = sched_time;
    if (sched_policy == POL_SRTF) begin
      for (int j = 0; j < sched_count; j++) begin
        if (slot_ready(j) && (sel < 0 || sched_left[j] < sched_left[sel])) sel = j;
      end
    end else if (sched_policy == POL_RR) begin
      start = (sched_rot < sched_count) ? sched_rot : 0;
      for (int j = 0; j < sched_count && sel < 0; j++) begin
        k = start + j;
        if (k >= sched_count) k -= sched_count;
        if (slot_ready(k)) sel = k;
      end
    end else begin
      // In load order the first unfinished task blocks all later ones.
      for (int j = 0; j < sched_count && !hit; j++) begin
        if (sched_left[j] != 16'd0) begin
          hit = 1'b1;
          if (sched_arrival[j] <= sched_time) sel = j;
        end
      end
    end
    if (sel >= 0) begin
      r.running_valid    = 1'b1;
      r.running_task     = sel[3:0];
      r.remaining_before = sched_left[sel];
      sched_left[sel]    = sched_left[sel] - 16'd1;
      if (sched_policy == POL_RR) sched_rot = (sel + 1 < sched_count) ? sel + 1 : 0;
      if (sched_left[sel] == 16'd0) begin
        comp = (sched_time == 16'hFFFF) ? sched_time : sched_time + 16'd1;
        resp = (comp >= sched_arrival[sel]) ? comp - sched_arrival[sel] : 16'd0;
        r.finished    = 1'b1;
        r.finish_at   = comp;
        r.turnaround  = resp;
        r.queue_delay = (resp >= sched_service[sel]) ? resp - sched_service[sel] : 16'd0;
      end
    end else if (sched_policy == POL_RR) begin
      sched_rot = 0;
    end
    r.all_done = sched_all_done();
    if (sched_time != 16'hFFFF) sched_time = sched_time + 16'd1;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Offers one beat after an optional gap and updates the model once it is taken.
  task automatic send_item(input logic cmd, input logic [15:0] arr, input logic [15:0] svc,
                           input bit typed, input tick_report_t want);
    int           gap;
    tick_report_t r;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 6);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {svc, arr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_TICK) begin
      r = schedule_tick();
      if (r.running_valid) ticks_run++;
      else ticks_idle++;
      if (r.finished) completions++;
      pending_ticks.push_back(typed ? want : r);
    end else begin
      table_append(arr, svc);
    end
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] pol);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = pol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sched_policy = pol;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off that fills the block up.
  initial begin
    out_tready = 1'b0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready = !rst_n ? 1'b0 : (steady || $urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      mon_got.tick_time        = out_tdata[15:0];
      mon_got.running_valid    = out_tdata[16];
      mon_got.running_task     = out_tdata[20:17];
      mon_got.remaining_before = out_tdata[36:21];
      mon_got.finished         = out_tdata[37];
      mon_got.finish_at        = out_tdata[53:38];
      mon_got.turnaround       = out_tdata[69:54];
      mon_got.queue_delay      = out_tdata[85:70];
      mon_got.all_done         = out_tdata[86];
      if (pending_ticks.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        fails++;
      end else begin
        mon_want = pending_ticks.pop_front();
        check_field("tick_time", mon_want.tick_time, mon_got.tick_time);
        check_field("running_valid", mon_want.running_valid, mon_got.running_valid);
        check_field("running_task", mon_want.running_task, mon_got.running_task);
        check_field("remaining_before", mon_want.remaining_before,
                    mon_got.remaining_before);
        check_field("finished", mon_want.finished, mon_got.finished);
        check_field("finish_at", mon_want.finish_at, mon_got.finish_at);
        check_field("turnaround", mon_want.turnaround, mon_got.turnaround);
        check_field("queue_delay", mon_want.queue_delay, mon_got.queue_delay);
        check_field("all_done", mon_want.all_done, mon_got.all_done);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_task_tick_scheduler_core NOT OK");
    $finish;
  end

  initial begin
    int          k;
    bit          do_load;
    logic [15:0] a;
    logic [15:0] s;
    int          near;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CMD_LOAD;
    fails         = 0;
    results_seen  = 0;
    loads_taken   = 0;
    loads_refused = 0;
    ticks_run     = 0;
    ticks_idle    = 0;
    completions   = 0;
    steady        = 1'b0;
    sched_count   = 0;
    sched_time    = '0;
    sched_rot     = 0;
    sched_policy  = POL_FIFO;
    for (int j = 0; j < N_SLOTS; j++) begin
      sched_arrival[j] = '0;
      sched_service[j] = '0;
      sched_left[j]    = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: begin
          write_policy(dir_tab[i].val_a[POLICY_W-1:0]);
        end
        ROW_LOAD: begin
          send_item(CMD_LOAD, dir_tab[i].val_a, dir_tab[i].val_b, 1'b0, NO_WANT);
        end
        default: begin
          send_item(CMD_TICK, 16'd0, 16'd0, dir_tab[i].typed, dir_tab[i].want);
        end
      endcase
    end

    // Random phases. The last two table slots are kept for the extreme tasks,
    // loaded late so that the earlier phases see tasks that can finish.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_policy(phase_pol[phase]);
      steady = (phase == 3);
      k = 0;
      while (k < PHASE_ITEMS) begin
        do_load = 1'b0;
        if (phase >= 5 && sched_count < N_SLOTS) begin
          do_load = 1'b1;
        end else if (phase < 5 && sched_count < N_SLOTS - 2 &&
                     (sched_all_done() || $urandom_range(0, 19) == 0)) begin
          do_load = 1'b1;
        end
        if (do_load) begin
          near = int'(sched_time) + $urandom_range(0, 40);
          a = (near > 65535) ? 16'hFFFF : near[15:0];
          s = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 3))
                                          : 16'($urandom_range(1, 120));
          if (sched_count == N_SLOTS - 2) begin
            a = 16'd0;
            s = 16'hFFFF;
          end else if (sched_count == N_SLOTS - 1) begin
            a = 16'hFFFF;
            s = 16'd1;
          end
          send_item(CMD_LOAD, a, s, 1'b0, NO_WANT);
          k++;
        end else if (sched_count == N_SLOTS && $urandom_range(0, 9) == 0) begin
          // A full table refuses loads; these only stir the data bits.
          send_item(CMD_LOAD, 16'($urandom), 16'($urandom), 1'b0, NO_WANT);
        end else begin
          send_item(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, NO_WANT);
          k++;
        end
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    steady    = 1'b1;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d task loads (%0d refused on a full table) under all policies.",
             loads_taken, loads_refused);
    $display("Ticks: %0d with work, %0d idle, %0d task completions.",
             ticks_run, ticks_idle, completions);
    if (fails == 0) begin
      $display("tb_task_tick_scheduler_core OK");
    end else begin
      $display("tb_task_tick_scheduler_core NOT OK");
    end
    $finish;
  end

endmodule
